// ----- hw/rtl/shp_pkg.sv -----
// Package: payload structs, register indexes and command codes of the histogram block.
package shp_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BIN_MIN   = 2'd0,
    REG_BIN_DELTA = 2'd1,
    REG_BINS_USED = 2'd2,
    REG_MIN_GOOD  = 2'd3
  } reg_e;

  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDataWidth = 16;

  typedef struct packed {
    logic [1:0]   command;
    logic signed [15:0] sample;
    logic         sample_present;
    logic [8:0]   percent;
  } in_item_t;

  typedef struct packed {
    logic         found;
    logic signed [31:0] result_value;
    logic         count_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_Q_MUL,
    ST_Q_RD,
    ST_Q_WALK,
    ST_OUT
  } state_e;

endpackage

// ----- hw/rtl/shp_front.sv -----
// Front end: accepts beats and queues them for the engine.
module shp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  shp_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output shp_pkg::in_item_t q_data_o
);
  import shp_pkg::*;

  in_item_t    mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/shp_engine.sv -----
// Back end: divider, histogram memory, query walk and output register.
module shp_engine #(
  parameter int unsigned MaxBins = 256,
  parameter int unsigned CountWidth = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  shp_pkg::in_item_t  cmd_i,
  input  logic [15:0]        bin_min_i,
  input  logic [15:0]        bin_delta_i,
  input  logic [8:0]         bins_used_i,
  input  logic [15:0]        min_good_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shp_pkg::out_item_t out_data_o
);
  import shp_pkg::*;

  localparam int unsigned BinW = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned NW = BinW + 1;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  state_e state_q, state_d;

  logic [CountWidth-1:0] mem_q [MaxBins];
  logic [CountWidth-1:0] rdata_q;
  logic [CountWidth-1:0] total_q;
  logic [BinW:0]   clr_q;
  logic            clr_busy;

  in_item_t        item_q;
  logic [16:0]     rem_q;
  logic [16:0]     quo_q;
  logic [4:0]      step_q;
  logic [15:0]     dlt_q;
  logic [BinW-1:0] idx_q;
  logic [NW-1:0]   nbins;
  logic [CountWidth+8:0] target_q;
  logic [CountWidth+8:0] cum_q;
  out_item_t       res_q;
  logic            res_v_q;

  always_comb begin
    if (bins_used_i == 9'd0) begin
      nbins = NW'(1);
    end else if ({23'd0, bins_used_i} > 32'(MaxBins)) begin
      nbins = NW'(MaxBins);
    end else begin
      nbins = NW'(bins_used_i);
    end
  end

  assign clr_busy    = (32'(clr_q) < 32'(MaxBins));
  assign cmd_ready_o = (state_q == ST_IDLE) && !clr_busy && !res_v_q;
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;

  // signed difference and shifted partial remainder
  logic signed [16:0] diff;
  logic [17:0]        trial;
  logic [16:0]        rem_sh;
  assign diff   = 17'(signed'(item_q.sample)) - 17'(signed'(bin_min_i));
  assign rem_sh = {rem_q[15:0], quo_q[16]};
  assign trial  = {1'b0, rem_sh} - {2'b0, dlt_q};

  logic [BinW-1:0] bin_sel;
  always_comb begin
    if (quo_q >= 17'(nbins)) bin_sel = BinW'(nbins - NW'(1));
    else bin_sel = quo_q[BinW-1:0];
  end

  logic last_bin;
  assign last_bin = ({1'b0, idx_q} + NW'(1)) >= nbins;

  logic [CountWidth+8:0] cum_n;
  assign cum_n = cum_q + (CountWidth+9)'(rdata_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          if (cmd_i.command == CMD_QUERY) state_d = ST_Q_MUL;
          else if ((cmd_i.command == CMD_ADD || cmd_i.command == CMD_REMOVE)
                   && cmd_i.sample_present) state_d = ST_DIV;
          else state_d = ST_OUT;
        end
      end
      ST_DIV:    if (step_q == 5'd17) state_d = ST_UPD_RD;
      ST_UPD_RD: state_d = ST_UPD_WR;
      ST_UPD_WR: state_d = ST_OUT;
      ST_Q_MUL: begin
        if (32'(total_q) < 32'(min_good_i)) state_d = ST_OUT;
        else state_d = ST_Q_RD;
      end
      ST_Q_RD:   state_d = ST_Q_WALK;
      ST_Q_WALK: if (cum_n >= target_q || last_bin) state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q   <= '0;
      total_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy) clr_q <= clr_q + 1'b1;
      if (res_v_q && out_ready_i) res_v_q <= 1'b0;
      if (state_q == ST_UPD_WR) begin
        if (item_q.command == CMD_ADD) begin
          if (total_q != CountMax) total_q <= total_q + 1'b1;
        end else if (total_q != '0) begin
          total_q <= total_q - 1'b1;
        end
      end
      if (state_q == ST_OUT) res_v_q <= 1'b1;
    end
  end

  // memory: one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      mem_q[clr_q[BinW-1:0]] <= '0;
    end else if (state_q == ST_UPD_WR) begin
      if (item_q.command == CMD_ADD) begin
        if (rdata_q != CountMax) mem_q[idx_q] <= rdata_q + 1'b1;
      end else if (rdata_q != '0) begin
        mem_q[idx_q] <= rdata_q - 1'b1;
      end
    end
    rdata_q <= mem_q[(state_q == ST_DIV) ? bin_sel :
                     (state_q == ST_Q_WALK) ? BinW'(idx_q + 1'b1) : idx_q];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_q <= cmd_i;
        step_q <= '0;
        dlt_q  <= (bin_delta_i == 16'd0) ? 16'd1 : bin_delta_i;
        rem_q  <= '0;
        idx_q  <= '0;
        cum_q  <= '0;
        if (!res_v_q) res_q <= '0;
      end
      ST_DIV: begin
        if (step_q == 5'd0) begin
          quo_q <= diff[16] ? 17'd0 : {diff[15:0], 1'b0};
          if (diff[16]) step_q <= 5'd17;
          else step_q <= 5'd1;
        end else if (step_q != 5'd17) begin
          if (!trial[17]) begin
            rem_q <= trial[16:0];
            quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[15:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
        end else begin
          idx_q <= bin_sel;
        end
      end
      ST_UPD_RD: ;
      ST_UPD_WR: begin
        if (item_q.command == CMD_REMOVE)
          res_q.count_error <= (total_q == '0) || (rdata_q == '0);
      end
      ST_Q_MUL: begin
        target_q <= ((CountWidth+9)'((item_q.percent > 9'd256) ? 9'd256 : item_q.percent)
                     * (CountWidth+9)'(total_q)) >> 8;
      end
      ST_Q_RD: ;
      ST_Q_WALK: begin
        cum_q <= cum_n;
        if (cum_n >= target_q) begin
          res_q.found <= 1'b1;
          res_q.result_value <= 32'(signed'(bin_min_i)) + 32'(dlt_q) * 32'(idx_q);
        end else if (!last_bin) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/sliding_histogram_percentile.sv -----
// Top level: config registers, front queue and histogram engine.
//  channel | dir | handshake                | payload
//  in      | in  | in_valid_i/in_ready_o    | in_data_i (in_item_t)
//  out     | out | out_valid_o/out_ready_i  | out_data_o (out_item_t)
//  cfg     | in  | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
// Beats wait in the queue; the engine then handles one at a time.
// Add/remove: the engine divides, reads the bin, writes it and offers the result;
//   a sample below bin_min skips the remaining divide steps. Missing sample or command 3: result offered directly.
// Query: multiply, read, then walk the bins up to bins_used; below min_good, straight to output.
// The engine takes its next beat only after its result has been taken.
// After reset the bin memory is cleared before the engine takes beats.
// A held result stalls the engine only; the 2-deep queue keeps taking beats until full.
module sliding_histogram_percentile #(
  parameter int unsigned MaxBins = 256,
  parameter int unsigned CountWidth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  shp_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output shp_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [shp_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [shp_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import shp_pkg::*;

  logic [15:0] bin_min_q, bin_delta_q, min_good_q;
  logic [8:0]  bins_used_q;
  logic        qv, qr;
  in_item_t    qd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_min_q   <= 16'd0;
      bin_delta_q <= 16'd1;
      bins_used_q <= 9'd256;
      min_good_q  <= 16'd0;
    end else if (cfg_valid_i && cfg_index_i[7:2] == 6'd0) begin
      unique case (reg_e'(cfg_index_i[1:0]))
        REG_BIN_MIN:   bin_min_q   <= cfg_data_i;
        REG_BIN_DELTA: bin_delta_q <= cfg_data_i;
        REG_BINS_USED: bins_used_q <= cfg_data_i[8:0];
        REG_MIN_GOOD:  min_good_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  shp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  shp_engine #(.MaxBins(MaxBins), .CountWidth(CountWidth)) u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qd),
    .bin_min_i(bin_min_q), .bin_delta_i(bin_delta_q), .bins_used_i(bins_used_q),
    .min_good_i(min_good_q), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// ----- hw/rtl/shp_checker.sv -----
// Checker: port-level assertions for the histogram block, bound to the top level.
module shp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input shp_pkg::out_item_t out_data_i
);
  import shp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("out beat dropped");
  a_found_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_data_i.found && out_data_i.count_error))
    else $error("found with error");
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.found |-> out_data_i.result_value == 32'sd0)
    else $error("value without found");
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i) else $error("output after reset");
endmodule

bind sliding_histogram_percentile shp_checker u_chk (
  .clk_i, .rst_ni, .out_valid_i(out_valid_o), .out_ready_i(out_ready_i),
  .out_data_i(out_data_o)
);
